// File: src/enint_pkg.sv
// shared types and constants for the energy integrator
`timescale 1ns / 1ps
`default_nettype none

package enint_pkg;

  localparam int ACC_WIDTH    = 63;
  localparam int TIME_WIDTH   = 32;
  localparam int STAMP_WIDTH  = 32;
  localparam int POWER_WIDTH  = 21;
  localparam int GAP_WIDTH    = 32;
  localparam int ENERGY_WIDTH = 63;
  localparam int DELTA_WIDTH  = POWER_WIDTH + TIME_WIDTH;
  localparam int SUM_WIDTH    = ((ACC_WIDTH > DELTA_WIDTH) ? ACC_WIDTH : DELTA_WIDTH) + 1;

  localparam int IN_DATA_WIDTH  = 56;
  localparam int IN_USER_WIDTH  = 1;
  localparam int OUT_DATA_WIDTH = 96;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ADD,
    OP_SUB,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [DELTA_WIDTH-1:0] delta;
    logic [GAP_WIDTH-1:0]   gap;
    logic                   cont;
  } stage_t;

endpackage

`default_nettype wire

// File: src/enint_front.sv
// continuity tracking, elapsed time and power times time product
`timescale 1ns / 1ps
`default_nettype none

module enint_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic                             step,
  input  wire logic                             command,
  input  wire logic                             sample_valid,
  input  wire logic                             status_ok,
  input  wire logic [enint_pkg::STAMP_WIDTH-1:0] timestamp_ms,
  input  wire logic signed [enint_pkg::POWER_WIDTH-1:0] power_mw,
  output logic                                  stage_valid,
  output enint_pkg::stage_t                     stage
);
  import enint_pkg::*;

  logic [TIME_WIDTH-1:0]  last_time;
  logic [GAP_WIDTH-1:0]   gap_counter;
  logic                   have_previous;
  logic [TIME_WIDTH-1:0]  stamp;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [POWER_WIDTH-1:0] magnitude;
  logic [DELTA_WIDTH-1:0] product;
  op_t                    op_next;
  op_t                    stage_op;
  logic [DELTA_WIDTH-1:0] stage_delta;

  assign stamp     = timestamp_ms[TIME_WIDTH-1:0];
  assign elapsed   = stamp - last_time;
  assign magnitude = power_mw[POWER_WIDTH-1] ? (~power_mw + POWER_WIDTH'(1'b1)) : power_mw;
  assign product   = DELTA_WIDTH'(magnitude) * DELTA_WIDTH'(elapsed);

  always_comb begin
    priority if (command) begin
      op_next = OP_CLEAR;
    end else if (!sample_valid || !status_ok || !have_previous) begin
      op_next = OP_HOLD;
    end else if (power_mw[POWER_WIDTH-1]) begin
      op_next = OP_SUB;
    end else begin
      op_next = OP_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time     <= '0;
      gap_counter   <= '0;
      have_previous <= 1'b0;
    end else if (accept) begin
      priority if (command) begin
        last_time     <= '0;
        gap_counter   <= '0;
        have_previous <= 1'b0;
      end else if (!sample_valid || !status_ok) begin
        if (have_previous) begin
          gap_counter <= gap_counter + GAP_WIDTH'(1'b1);
        end
        have_previous <= 1'b0;
      end else begin
        have_previous <= 1'b1;
        last_time     <= stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      stage_op    <= OP_HOLD;
    end else if (accept) begin
      stage_valid <= 1'b1;
      stage_op    <= op_next;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_delta <= product;
    end
  end

  // held state is what the pending beat reports
  assign stage = {stage_op, stage_delta, gap_counter, have_previous};

`ifndef SYNTHESIS
  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    accept && command |=> gap_counter == '0 && !have_previous && last_time == '0)
    else $error("clear beat left continuity state behind");

  a_bad_breaks: assert property (@(posedge clk) disable iff (rst)
    accept && !command && (!sample_valid || !status_ok) |=> !have_previous)
    else $error("bad sample kept continuity");

  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(gap_counter) && $stable(last_time) && $stable(have_previous))
    else $error("continuity state moved without a beat");
`endif

endmodule

`default_nettype wire

// File: src/enint_accum.sv
// energy accumulator with clamp and saturation, and the result register
`timescale 1ns / 1ps
`default_nettype none

module enint_accum (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              step,
  input  wire logic                              drain,
  input  wire enint_pkg::stage_t                 stage,
  output logic                                   result_valid,
  output logic [enint_pkg::ENERGY_WIDTH-1:0]     energy_total,
  output logic [enint_pkg::GAP_WIDTH-1:0]        gap_total,
  output logic                                   continuous
);
  import enint_pkg::*;

  logic [ACC_WIDTH-1:0] energy_acc;
  logic [ACC_WIDTH-1:0] energy_acc_next;
  logic [SUM_WIDTH-1:0] acc_wide;
  logic [SUM_WIDTH-1:0] delta_wide;
  logic [SUM_WIDTH-1:0] sum;

  assign acc_wide   = SUM_WIDTH'(energy_acc);
  assign delta_wide = SUM_WIDTH'(stage.delta);
  assign sum        = acc_wide + delta_wide;

  always_comb begin
    unique case (stage.op)
      OP_ADD: begin
        energy_acc_next = (sum > SUM_WIDTH'(ACC_MAX)) ? ACC_MAX : sum[ACC_WIDTH-1:0];
      end
      OP_SUB: begin
        energy_acc_next = (delta_wide >= acc_wide) ? '0
                        : energy_acc - ACC_WIDTH'(stage.delta);
      end
      OP_CLEAR: begin
        energy_acc_next = '0;
      end
      default: begin
        energy_acc_next = energy_acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_acc   <= '0;
      result_valid <= 1'b0;
    end else if (step) begin
      energy_acc   <= energy_acc_next;
      result_valid <= 1'b1;
    end else if (drain) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      gap_total  <= stage.gap;
      continuous <= stage.cont;
    end
  end

  assign energy_total = ENERGY_WIDTH'(energy_acc);

`ifndef SYNTHESIS
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    step && stage.op == OP_CLEAR |=> energy_acc == '0)
    else $error("clear beat did not zero the total");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    step && stage.op == OP_ADD |=> energy_acc >= $past(energy_acc))
    else $error("forward power reduced the total");

  a_sub_shrinks: assert property (@(posedge clk) disable iff (rst)
    step && stage.op == OP_SUB |=> energy_acc <= $past(energy_acc))
    else $error("reverse power raised the total");
`endif

endmodule

`default_nettype wire

// File: src/energy_integrator_unit.sv
// energy integrator top level: stream handshakes around the two stages
//
// input beats carry a power sample or a clear command (tuser bit 0 set).
// a good sample after another good sample adds power times the elapsed
// milliseconds to a milliwatt-millisecond total (Wh = total / 3.6e9);
// negative power subtracts, the total clamps at zero and saturates at its
// maximum. a bad or not-ok sample breaks continuity and counts a gap if a
// good sample was held. every input beat gives exactly one output beat with
// the total, the gap count and the continuity flag after that beat.
// the elapsed time and the 21 x 32 product are registered in the product
// stage, then the accumulator add with clamp in the result register.
// throughput: one beat per cycle while the receiver takes each result, set
// by the single accumulator register that every beat updates once.
// reset clears the total, the gap count and continuity and empties both
// stages. when the receiver stalls the result register holds, the product
// stage fills and s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module energy_integrator_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // sample_valid, status_ok, timestamp_ms[31:0], power_mw[20:0], zero pad
  input  wire logic [enint_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  // command
  input  wire logic [enint_pkg::IN_USER_WIDTH-1:0]  s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // energy_total[62:0], gap_total[31:0], continuous
  output logic [enint_pkg::OUT_DATA_WIDTH-1:0]      m_tdata
);
  import enint_pkg::*;

  localparam int TS_LO  = 2;
  localparam int PWR_LO = TS_LO + STAMP_WIDTH;
  localparam int PAD_W  = IN_DATA_WIDTH - PWR_LO - POWER_WIDTH;

  logic                   accept;
  logic                   step;
  logic                   drain;
  logic                   out_free;
  logic                   stage_valid;
  stage_t                 stage;
  logic [ENERGY_WIDTH-1:0] energy_total;
  logic [GAP_WIDTH-1:0]    gap_total;
  logic                    continuous;
  logic [PAD_W-1:0]        pad_unused;

  assign drain    = m_tvalid && m_tready;
  assign out_free = !m_tvalid || m_tready;
  assign step     = stage_valid && out_free;
  assign s_tready = !stage_valid || out_free;
  assign accept   = s_tvalid && s_tready;
  assign pad_unused = s_tdata[IN_DATA_WIDTH-1 -: PAD_W];

  enint_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .step         (step),
    .command      (s_tuser[0]),
    .sample_valid (s_tdata[0]),
    .status_ok    (s_tdata[1]),
    .timestamp_ms (s_tdata[TS_LO +: STAMP_WIDTH]),
    .power_mw     (s_tdata[PWR_LO +: POWER_WIDTH]),
    .stage_valid  (stage_valid),
    .stage        (stage)
  );

  enint_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .drain        (drain),
    .stage        (stage),
    .result_valid (m_tvalid),
    .energy_total (energy_total),
    .gap_total    (gap_total),
    .continuous   (continuous)
  );

  assign m_tdata = {continuous, gap_total, energy_total};

`ifndef SYNTHESIS
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    accept |-> pad_unused == '0 || !accept)
    else $error("input pad bits set");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> s_tready)
    else $error("input stalled with an empty product stage");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
// testbench for energy_integrator_unit: scoreboard with its own energy model and stream drivers
`timescale 1ns / 1ps

module testbench;
  import enint_pkg::*;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam logic signed [POWER_WIDTH-1:0] POWER_MAX = {1'b0, {(POWER_WIDTH-1){1'b1}}};
  localparam logic signed [POWER_WIDTH-1:0] POWER_MIN = {1'b1, {(POWER_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic                    cont;
    logic [GAP_WIDTH-1:0]    gaps;
    logic [ENERGY_WIDTH-1:0] energy;
  } totals_t;

  class energy_ledger;
    logic [ACC_WIDTH-1:0]   energy;
    logic [TIME_WIDTH-1:0]  last_stamp;
    logic [GAP_WIDTH-1:0]   gaps;
    logic                   held;
    totals_t                expected_totals[$];
    int                     failures;

    function new();
      failures = 0;
      clear_totals();
    endfunction

    function void clear_totals();
      energy     = '0;
      last_stamp = '0;
      gaps       = '0;
      held       = 1'b0;
    endfunction

    function void note_input(logic cmd, logic [IN_DATA_WIDTH-1:0] data);
      logic                          valid;
      logic                          ok;
      logic [TIME_WIDTH-1:0]         stamp;
      logic [TIME_WIDTH-1:0]         elapsed;
      logic signed [POWER_WIDTH-1:0] power;
      longint                        power_wide;
      logic [63:0]                   delta;
      logic [63:0]                   room;
      totals_t                       t;
      valid = data[0];
      ok    = data[1];
      stamp = data[2 +: TIME_WIDTH];
      power = data[34 +: POWER_WIDTH];
      if (cmd == CMD_CLEAR) begin
        clear_totals();
      end else if (!valid || !ok) begin
        if (held) gaps = gaps + GAP_WIDTH'(1'b1);
        held = 1'b0;
      end else if (!held) begin
        held       = 1'b1;
        last_stamp = stamp;
      end else begin
        elapsed    = stamp - last_stamp;
        last_stamp = stamp;
        if (elapsed != 0) begin
          power_wide = power;
          delta = (power_wide < 0) ? 64'(-power_wide) : 64'(power_wide);
          delta = delta * 64'(elapsed);
          if (power_wide >= 0) begin
            room = 64'(ACC_MAX) - 64'(energy);
            energy = (delta > room) ? ACC_MAX : energy + ACC_WIDTH'(delta);
          end else begin
            energy = (delta >= 64'(energy)) ? '0 : energy - ACC_WIDTH'(delta);
          end
        end
      end
      t.energy = energy[ENERGY_WIDTH-1:0];
      t.gaps   = gaps;
      t.cont   = held;
      expected_totals.push_back(t);
    endfunction

    function void check_result(logic [OUT_DATA_WIDTH-1:0] data);
      totals_t want;
      totals_t got;
      got = data;
      if (expected_totals.size() == 0) begin
        if (failures < 10) $display("unexpected result beat: %h", data);
        failures++;
      end else begin
        want = expected_totals.pop_front();
        if (got.energy !== want.energy || got.gaps !== want.gaps || got.cont !== want.cont) begin
          if (failures < 10)
            $display("mismatch: energy %0d/%0d gaps %0d/%0d cont %0b/%0b (expected/actual)",
                     want.energy, got.energy, want.gaps, got.gaps, want.cont, got.cont);
          failures++;
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_DATA_WIDTH-1:0]  s_tdata;
  logic [IN_USER_WIDTH-1:0]  s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_DATA_WIDTH-1:0] m_tdata;

  int send_idle;
  int recv_idle;
  energy_ledger ledger;

  energy_integrator_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result checks and input notes share one process so their order is fixed
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) ledger.check_result(m_tdata);
      if (s_tvalid && s_tready) ledger.note_input(s_tuser[0], s_tdata);
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_beat(logic cmd, logic valid, logic ok, logic [STAMP_WIDTH-1:0] stamp,
                           logic signed [POWER_WIDTH-1:0] power);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, power, stamp, ok, valid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic run_directed();
    send_beat(CMD_SAMPLE, 1'b0, 1'b1, 32'd10, 21'sd5);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 32'd20, 21'sd5);
    send_beat(CMD_CLEAR, 1'b0, 1'b0, 32'd0, 21'sd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'd100, 21'sd500);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'd100, POWER_MAX);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'd1100, POWER_MAX);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'd3100, POWER_MIN);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'd3500, 21'sd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'hffff_fff0, 21'sd1000);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'h0000_0010, 21'sd1);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'h0000_0005, 21'sd7);
    send_beat(CMD_SAMPLE, 1'b0, 1'b1, 32'd6, 21'sd7);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 32'd7, 21'sd7);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'hffff_ffff, -21'sd1);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'h0000_0000, -21'sd1);
    send_beat(CMD_SAMPLE, 1'b0, 1'b0, 32'hffff_ffff, POWER_MIN);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'h0, POWER_MAX);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'hffff_ffff, POWER_MAX);
    send_beat(CMD_CLEAR, 1'b1, 1'b1, 32'hffff_ffff, POWER_MAX);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'h8000_0000, -21'sd3);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 32'h8000_0001, -21'sd3);
    send_beat(CMD_CLEAR, 1'b0, 1'b1, 32'h1234_5678, POWER_MIN);
  endtask

  // build a large total with full power over maximal elapsed time, then pull it down
  task automatic climb_to_ceiling();
    logic [STAMP_WIDTH-1:0] stamp;
    stamp = $urandom;
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, stamp, POWER_MAX);
    repeat (20) begin
      stamp = stamp - STAMP_WIDTH'(1'b1);
      send_beat(CMD_SAMPLE, 1'b1, 1'b1, stamp, POWER_MAX);
    end
    repeat (3) begin
      stamp = stamp + 32'd1000;
      send_beat(CMD_SAMPLE, 1'b1, 1'b1, stamp, 21'($urandom_range(1, 1048575)));
    end
    repeat (4) begin
      stamp = stamp - STAMP_WIDTH'(1'b1);
      send_beat(CMD_SAMPLE, 1'b1, 1'b1, stamp, POWER_MIN);
    end
    send_beat(CMD_CLEAR, 1'($urandom), 1'($urandom), $urandom, 21'($urandom));
  endtask

  task automatic random_runs(int count);
    int                            issued;
    int                            len;
    int                            pick;
    logic [STAMP_WIDTH-1:0]        stamp;
    logic [STAMP_WIDTH-1:0]        step;
    logic signed [POWER_WIDTH-1:0] power;
    logic                          valid;
    logic                          ok;
    issued = 0;
    while (issued < count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_beat(CMD_CLEAR, 1'($urandom), 1'($urandom), $urandom, 21'($urandom));
        issued++;
      end else if (pick < 18) begin
        // broken sample, occasionally a stray good one
        case ($urandom_range(2))
          0: begin valid = 1'b0; ok = 1'($urandom); end
          1: begin valid = 1'($urandom); ok = 1'b0; end
          default: begin valid = 1'($urandom); ok = 1'($urandom); end
        endcase
        send_beat(CMD_SAMPLE, valid, ok, $urandom, 21'($urandom));
        issued++;
      end else begin
        len   = $urandom_range(2, 12);
        stamp = $urandom;
        repeat (len) begin
          if ($urandom_range(9) < 7) power = {1'b0, 20'($urandom)};
          else power = 21'($urandom);
          send_beat(CMD_SAMPLE, 1'b1, 1'b1, stamp, power);
          case ($urandom_range(9))
            0: step = '0;
            1: step = $urandom;
            default: step = $urandom_range(1, 5000);
          endcase
          stamp = stamp + step;
        end
        issued += len;
      end
    end
  endtask

  initial begin
    ledger = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    m_tready <= 1'b0;
    send_idle = 8;
    recv_idle = 52;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    random_runs(120);
    send_idle = 52;
    recv_idle = 8;
    climb_to_ceiling();
    random_runs(110);
    send_idle = 0;
    recv_idle = 0;
    random_runs(120);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_totals.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ledger.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
